### rtl/ils_pkg.sv
// shared types, codes and sizes of the indexed list store
// no dependencies; imported by every other file of the block but ils_ram
package ils_pkg;

  // list capacity and derived widths
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // fixed field widths of the transactions
  localparam int unsigned OPC_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned FPOS_W = 6;
  localparam int unsigned CNTO_W = 7;

  // compare width for position against count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // opcodes
  localparam logic [OPC_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPC_W-1:0] OP_POP    = 3'd1;
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OPC_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OPC_W-1:0] OP_SEARCH = 3'd4;
  localparam logic [OPC_W-1:0] OP_GET    = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // work selected once an operation has passed its checks
  typedef enum logic [2:0] {
    K_NOP,
    K_APPEND,
    K_POP,
    K_INSERT,
    K_DELETE,
    K_SEARCH,
    K_GET
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the input item and plan the walk
    logic rd;       // read one entry at the walk pointer
    logic proc;     // use the data of the previous read
    logic fin;      // final write, count update, result register load
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
  } stat_t;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] read_word;
    logic                     found;
    logic [FPOS_W-1:0]        found_position;
    logic [CNTO_W-1:0]        count;
    logic                     is_empty;
  } res_t;

endpackage

### rtl/ils_if.sv
// request and result channel interfaces of the indexed list store
// depends on ils_pkg for the field widths
interface ils_in_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] word;

  modport source (output valid, output opcode, output position, output word, input ready);
  modport sink   (input valid, input opcode, input position, input word, output ready);
endinterface

interface ils_out_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [WORD_W-1:0] read_word;
  logic                     found;
  logic [FPOS_W-1:0]        found_position;
  logic [CNTO_W-1:0]        count;
  logic                     is_empty;

  modport source (output valid, output status, output read_word, output found,
                  output found_position, output count, output is_empty, input ready);
  modport sink   (input valid, input status, input read_word, input found,
                  input found_position, input count, input is_empty, output ready);
endinterface

### rtl/ils_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ils_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ils_datapath.sv
// datapath: operation checks, walk pointers, entry ram, count and result register
// depends on ils_pkg and ils_ram
module ils_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ils_pkg::in_item_t item_i,
  input  ils_pkg::cmd_t    cmd_i,
  output ils_pkg::stat_t   stat_o,
  output ils_pkg::res_t    res_o
);
  import ils_pkg::*;

  kind_e                 kind_q, kind_c;
  logic [ST_W-1:0]       status_q, status_c;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rem_q, rem_c;
  logic [IDX_W-1:0]      rptr_q, rptr_c;
  logic [IDX_W-1:0]      prev_q;
  logic [IDX_W-1:0]      pos_q;
  logic [WORD_W-1:0]     word_q;
  logic [WORD_W-1:0]     rd_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hitpos_q;
  res_t                  res_q;

  logic [CMP_W-1:0]      pos_x, cnt_x;
  logic                  full, empty;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_W-1:0]     wdata;
  logic [WORD_W-1:0]     rdata;

  assign pos_x = CMP_W'(item_i.position);
  assign cnt_x = CMP_W'(count_q);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // checks and walk plan for the incoming operation
  always_comb begin
    kind_c   = K_NOP;
    status_c = ST_OK;
    rem_c    = '0;
    rptr_c   = '0;
    unique case (item_i.opcode)
      OP_APPEND: begin
        if (full) status_c = ST_FULL;
        else      kind_c   = K_APPEND;
      end
      OP_POP: begin
        if (empty) status_c = ST_EMPTY;
        else       kind_c   = K_POP;
      end
      OP_INSERT: begin
        priority if (pos_x > cnt_x) status_c = ST_RANGE;
        else if (full)              status_c = ST_FULL;
        else begin
          kind_c = K_INSERT;
          rem_c  = CNT_W'(cnt_x - pos_x);
          rptr_c = IDX_W'(count_q - 1'b1);
        end
      end
      OP_DELETE: begin
        priority if (empty)          status_c = ST_EMPTY;
        else if (pos_x >= cnt_x)     status_c = ST_RANGE;
        else begin
          kind_c = K_DELETE;
          rem_c  = CNT_W'(cnt_x - pos_x - 1'b1);
          rptr_c = IDX_W'(pos_x + 1'b1);
        end
      end
      OP_SEARCH: begin
        kind_c = K_SEARCH;
        rem_c  = count_q;
      end
      OP_GET: begin
        priority if (empty)          status_c = ST_EMPTY;
        else if (pos_x >= cnt_x)     status_c = ST_RANGE;
        else begin
          kind_c = K_GET;
          rem_c  = CNT_W'(1);
          rptr_c = IDX_W'(pos_x);
        end
      end
      default: begin
      end
    endcase
  end

  // ram write port: shift moves during the walk, the new word at the end
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (cmd_i.proc && kind_q == K_INSERT) begin
      we    = 1'b1;
      waddr = IDX_W'(prev_q + 1'b1);
    end else if (cmd_i.proc && kind_q == K_DELETE) begin
      we    = 1'b1;
      waddr = IDX_W'(prev_q - 1'b1);
    end else if (cmd_i.fin && kind_q == K_APPEND) begin
      we    = 1'b1;
      waddr = IDX_W'(count_q);
      wdata = word_q;
    end else if (cmd_i.fin && kind_q == K_INSERT) begin
      we    = 1'b1;
      waddr = pos_q;
      wdata = word_q;
    end
  end

  always_comb begin
    unique case (kind_q)
      K_APPEND, K_INSERT: count_d = count_q + 1'b1;
      K_POP, K_DELETE:    count_d = count_q - 1'b1;
      default:            count_d = count_q;
    endcase
  end

  ils_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kind_q  <= K_NOP;
      rem_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        kind_q <= kind_c;
        rem_q  <= rem_c;
      end else if (cmd_i.rd) begin
        rem_q  <= rem_q - 1'b1;
      end
      if (cmd_i.fin) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_q <= status_c;
      rptr_q   <= rptr_c;
      pos_q    <= IDX_W'(item_i.position);
      word_q   <= item_i.word;
      hit_q    <= 1'b0;
      hitpos_q <= '0;
      rd_q     <= '0;
    end else begin
      if (cmd_i.rd) begin
        prev_q <= rptr_q;
        rptr_q <= (kind_q == K_INSERT) ? IDX_W'(rptr_q - 1'b1) : IDX_W'(rptr_q + 1'b1);
      end
      if (cmd_i.proc && kind_q == K_SEARCH && !hit_q && rdata == word_q) begin
        hit_q    <= 1'b1;
        hitpos_q <= prev_q;
      end
      if (cmd_i.proc && kind_q == K_GET) begin
        rd_q <= rdata;
      end
    end
    if (cmd_i.fin) begin
      res_q.status         <= status_q;
      res_q.read_word      <= (kind_q == K_GET) ? rd_q : '0;
      res_q.found          <= hit_q;
      res_q.found_position <= FPOS_W'(hitpos_q);
      res_q.count          <= CNTO_W'(count_d);
      res_q.is_empty       <= (count_d == '0);
    end
  end

  assign stat_o.walk_done = (rem_q == '0);
  assign res_o            = res_q;

endmodule

### rtl/ils_ctrl.sv
// controller: sequences capture, ram walk and finish, owns both handshakes
// depends on ils_pkg
module ils_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ils_pkg::stat_t stat_i,
  output ils_pkg::cmd_t  cmd_o
);
  import ils_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_TAIL
  } state_e;

  state_e state_q;
  logic   proc_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.rd      = (state_q == S_WALK) && !stat_i.walk_done;
  assign cmd_o.proc    = proc_q;
  assign cmd_o.fin     = (state_q == S_TAIL) && !proc_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      proc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      proc_q <= cmd_o.rd;
      if (cmd_o.fin)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_WALK;
        end
        S_WALK: begin
          if (stat_i.walk_done) state_q <= S_TAIL;
        end
        S_TAIL: begin
          if (cmd_o.fin) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/indexed_list_store.sv
// top level of the indexed list store: fixed-depth ordered list of signed words
// depends on ils_pkg, ils_if, ils_ram, ils_datapath and ils_ctrl
//
//   channel  dir  modport  payload
//   in_i     in   sink     opcode, position, word
//   out_o    out  source   status, read_word, found, found_position, count, is_empty
//
// walk: an item holds the block from capture to finish and reads n entries
//   on the way: n is count - position for insert, count - 1 - position for delete,
//   count for search and 1 for get; the entry ram moves one entry per cycle
//   through its single read port, and no new item is taken until the finish
// reset: clears the entry count, the walk plan and the controller state; the entry ram is not cleared
// stalls: a finished result waits in the output register while the next transaction
//   is taken; the finish step waits only while that register is full and not read
module indexed_list_store (
  input  logic      clk_i,
  input  logic      rst_ni,
  ils_in_if.sink    in_i,
  ils_out_if.source out_o
);
  import ils_pkg::*;

  cmd_t     cmd;
  stat_t    stat;
  in_item_t item;
  res_t     res;

  // request fields gathered for the datapath
  assign item.opcode   = in_i.opcode;
  assign item.position = in_i.position;
  assign item.word     = in_i.word;

  // sequencing of capture, walk and finish
  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // checks, entry ram, count and result register
  ils_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  // result fields straight from the output register
  assign out_o.status         = res.status;
  assign out_o.read_word      = res.read_word;
  assign out_o.found          = res.found;
  assign out_o.found_position = res.found_position;
  assign out_o.count          = res.count;
  assign out_o.is_empty       = res.is_empty;

`ifndef SYNTHESIS
  // an accepted transaction keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request taken while previous one still in progress");

  // shift writes and the final write never meet on the ram write port
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.proc && cmd.fin))
    else $error("two ram writes in one cycle");

  // a finish always presents a result in the next cycle
  a_fin_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> out_o.valid)
    else $error("finished transaction left no result");

  // ram reads only happen while a transaction is being worked on
  a_no_walk_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |-> !in_i.ready)
    else $error("ram walk while idle");
`endif

endmodule
